// ===== src/gbs_pkg.sv =====
// Shared constants and codes for the grid bilinear sampler.
`default_nettype none
package gbs_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 28;
  localparam int COUNT_W   = 9;
  localparam int CELL_W    = 32;
  localparam int STORE_AW  = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // fraction bits of a coordinate plus fraction bits of a scale
  localparam int PROD_FRAC = 38;

  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_COLS  = 256;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(256);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_ORIGIN = 3'd0,
    CFG_LON_ORIGIN = 3'd1,
    CFG_LAT_SCALE  = 3'd2,
    CFG_LON_SCALE  = 3'd3,
    CFG_ROWS       = 3'd4,
    CFG_COLS       = 3'd5
  } cfg_idx_t;

endpackage
`default_nettype wire

// ===== src/gbs_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module gbs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/grid_bilinear_sampler_unit.sv =====
// Top level: pipelined bilinear sampler over a stored fixed-point grid.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------
//  request | in_cmd in_cell_index in_cell_value            | start & !busy
//          | in_cell_valid in_latitude in_longitude        |
//  result  | out_value out_valid_res                       | out_strobe, 1 cycle
//  config  | cfg_index cfg_wdata                           | cfg_we
//
// One request per cycle; busy stays low. A query result passes through ten
// register stages (capture, subtract, scale multiply, locate, row multiply,
// corner RAM read, column weight multiply, column sum, row weight multiply,
// round). Loads write the four corner RAM copies at the read stage so loads
// and queries hit memory in request order. Reset clears valid bits and
// config; the grid store is not cleared. The receiver cannot stall the
// output.
`default_nettype none
module grid_bilinear_sampler_unit #(
  parameter int MAX_ROWS  = gbs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = gbs_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = gbs_pkg::DEF_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_cmd,
  input  wire logic [gbs_pkg::STORE_AW-1:0]   in_cell_index,
  input  wire logic signed [gbs_pkg::CELL_W-1:0]  in_cell_value,
  input  wire logic                           in_cell_valid,
  input  wire logic signed [gbs_pkg::COORD_W-1:0] in_latitude,
  input  wire logic signed [gbs_pkg::COORD_W-1:0] in_longitude,
  output logic                                out_strobe,
  output logic signed [gbs_pkg::CELL_W-1:0]   out_value,
  output logic                                out_valid_res,
  input  wire logic                           cfg_we,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbs_pkg::CFG_W-1:0]      cfg_wdata
);
  import gbs_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CWR  = $clog2(MAX_ROWS + 1);
  localparam int XW   = $clog2(MAX_COLS);
  localparam int CWC  = $clog2(MAX_COLS + 1);
  localparam int DW   = COORD_W + 1;
  localparam int MW   = DW + SCALE_W + 1;
  localparam int PW   = MW - 1 - (PROD_FRAC - F);
  localparam int AW0  = RW + CWC;
  localparam int AW   = (AW0 + 1 > STORE_AW) ? AW0 + 1 : STORE_AW;
  localparam int WW   = F + 1;
  localparam int P1W  = CELL_W + WW + 1;
  localparam int L1W  = P1W + 1;
  localparam int P2W  = L1W + WW + 1;
  localparam int ACW  = P2W + 1;
  localparam int ENT_W = CELL_W + 1;

  // ---------------- configuration ----------------
  logic signed [COORD_W-1:0] lat_origin_r, lon_origin_r;
  logic [SCALE_W-1:0] lat_scale_r, lon_scale_r;
  logic [COUNT_W-1:0] rows_cfg_r, cols_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_origin_r <= '0;
      lon_origin_r <= '0;
      lat_scale_r  <= SCALE_RST;
      lon_scale_r  <= SCALE_RST;
      rows_cfg_r   <= COUNT_RST;
      cols_cfg_r   <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAT_ORIGIN: lat_origin_r <= cfg_wdata[COORD_W-1:0];
        CFG_LON_ORIGIN: lon_origin_r <= cfg_wdata[COORD_W-1:0];
        CFG_LAT_SCALE:  lat_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_LON_SCALE:  lon_scale_r  <= cfg_wdata[SCALE_W-1:0];
        CFG_ROWS:       rows_cfg_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_COLS:       cols_cfg_r   <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, large counts saturate
  logic [CWR-1:0] rows;
  logic [CWC-1:0] cols;
  always_comb begin
    if (rows_cfg_r == '0) rows = CWR'(1);
    else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) rows = CWR'(MAX_ROWS);
    else rows = CWR'(rows_cfg_r);
    if (cols_cfg_r == '0) cols = CWC'(1);
    else if (32'(cols_cfg_r) > 32'(MAX_COLS)) cols = CWC'(MAX_COLS);
    else cols = CWC'(cols_cfg_r);
  end

  assign busy = 1'b0;
  wire accept = start && !busy;

  // ---------------- stage 1: capture ----------------
  logic s1_v_r, s1_q_r;
  logic [STORE_AW-1:0] s1_idx_r;
  logic [ENT_W-1:0] s1_ent_r;
  logic signed [COORD_W-1:0] s1_lat_r, s1_lon_r;

  // ---------------- stage 2: differences ----------------
  logic s2_v_r, s2_q_r;
  logic [STORE_AW-1:0] s2_idx_r;
  logic [ENT_W-1:0] s2_ent_r;
  logic signed [DW-1:0] s2_dlat_r, s2_dlon_r;

  // ---------------- stage 3: scaled products ----------------
  logic s3_v_r, s3_q_r;
  logic [STORE_AW-1:0] s3_idx_r;
  logic [ENT_W-1:0] s3_ent_r;
  logic signed [MW-1:0] s3_plat_r, s3_plon_r;

  // ---------------- stage 4: located cells ----------------
  logic s4_v_r, s4_q_r, s4_in_r;
  logic [STORE_AW-1:0] s4_idx_r;
  logic [ENT_W-1:0] s4_ent_r;
  logic [RW-1:0] s4_y0_r, s4_y1_r;
  logic [XW-1:0] s4_x0_r, s4_x1_r;
  logic [F-1:0] s4_ty_r, s4_tx_r;

  // ---------------- stage 5: row offsets, memory access ----------------
  logic s5_v_r, s5_q_r, s5_in_r;
  logic [STORE_AW-1:0] s5_idx_r;
  logic [ENT_W-1:0] s5_ent_r;
  logic [AW0-1:0] s5_r0_r, s5_r1_r;
  logic [XW-1:0] s5_x0_r, s5_x1_r;
  logic [F-1:0] s5_ty_r, s5_tx_r;

  // ---------------- stage 6: corner data ----------------
  logic s6_v_r, s6_in_r;
  logic [F-1:0] s6_ty_r, s6_tx_r;

  // ---------------- stage 7..9: weighting ----------------
  logic s7_v_r, s7_ok_r;
  logic [F-1:0] s7_ty_r;
  logic signed [P1W-1:0] s7_p00_r, s7_p01_r, s7_p10_r, s7_p11_r;
  logic s8_v_r, s8_ok_r;
  logic [F-1:0] s8_ty_r;
  logic signed [L1W-1:0] s8_lo_r, s8_up_r;
  logic s9_v_r, s9_ok_r;
  logic signed [P2W-1:0] s9_ml_r, s9_mu_r;

  typedef struct packed {
    logic          in;
    logic [12:0]   base;
    logic [12:0]   next;
    logic [F-1:0]  frac;
  } loc_t;

  function automatic loc_t locate(input logic signed [MW-1:0] prod,
                                  input logic [12:0] size);
    loc_t r;
    logic [PW-1:0] pos;
    logic [PW-1:0] lim;
    logic [13:0] b1;
    r = '0;
    pos = prod[MW-2 -: PW];
    lim = PW'({size - 13'd1, {F{1'b0}}});
    r.in = !prod[MW-1] && (pos <= lim);
    r.base = 13'(pos[PW-1:F]);
    r.frac = pos[F-1:0];
    b1 = {1'b0, r.base} + 14'd1;
    r.next = (b1 < {1'b0, size}) ? b1[12:0] : size - 13'd1;
    return r;
  endfunction

  loc_t loc_y, loc_x;
  assign loc_y = locate(s3_plat_r, 13'(rows));
  assign loc_x = locate(s3_plon_r, 13'(cols));

  // corner addresses wrap modulo the store depth
  logic [AW-1:0] a00, a01, a10, a11;
  assign a00 = AW'(s5_r0_r) + AW'(s5_x0_r);
  assign a01 = AW'(s5_r0_r) + AW'(s5_x1_r);
  assign a10 = AW'(s5_r1_r) + AW'(s5_x0_r);
  assign a11 = AW'(s5_r1_r) + AW'(s5_x1_r);

  wire ram_we = s5_v_r && (s5_q_r == CMD_LOAD);
  logic [ENT_W-1:0] c00, c01, c10, c11;

  gbs_ram #(.WIDTH(ENT_W), .DEPTH(STORE_DEPTH)) u_ram00 (
    .clk(clk), .we(ram_we), .waddr(s5_idx_r), .wdata(s5_ent_r),
    .raddr(a00[STORE_AW-1:0]), .rdata(c00));
  gbs_ram #(.WIDTH(ENT_W), .DEPTH(STORE_DEPTH)) u_ram01 (
    .clk(clk), .we(ram_we), .waddr(s5_idx_r), .wdata(s5_ent_r),
    .raddr(a01[STORE_AW-1:0]), .rdata(c01));
  gbs_ram #(.WIDTH(ENT_W), .DEPTH(STORE_DEPTH)) u_ram10 (
    .clk(clk), .we(ram_we), .waddr(s5_idx_r), .wdata(s5_ent_r),
    .raddr(a10[STORE_AW-1:0]), .rdata(c10));
  gbs_ram #(.WIDTH(ENT_W), .DEPTH(STORE_DEPTH)) u_ram11 (
    .clk(clk), .we(ram_we), .waddr(s5_idx_r), .wdata(s5_ent_r),
    .raddr(a11[STORE_AW-1:0]), .rdata(c11));

  logic [WW-1:0] wx1, wx0, wy1, wy0;
  assign wx1 = {1'b0, s6_tx_r};
  assign wx0 = {1'b1, {F{1'b0}}} - wx1;
  assign wy1 = {1'b0, s8_ty_r};
  assign wy0 = {1'b1, {F{1'b0}}} - wy1;

  logic signed [ACW-1:0] acc;
  assign acc = ACW'(s9_ml_r) + ACW'(s9_mu_r) + (ACW'(1) << (2 * F - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0; s8_v_r <= 1'b0;
      s9_v_r <= 1'b0; out_strobe <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r && (s5_q_r == CMD_QUERY);
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      s9_v_r <= s8_v_r;
      out_strobe <= s9_v_r;
    end

    s1_q_r   <= in_cmd;
    s1_idx_r <= in_cell_index;
    s1_ent_r <= {in_cell_valid, in_cell_value};
    s1_lat_r <= in_latitude;
    s1_lon_r <= in_longitude;

    s2_q_r    <= s1_q_r;
    s2_idx_r  <= s1_idx_r;
    s2_ent_r  <= s1_ent_r;
    s2_dlat_r <= DW'(s1_lat_r) - DW'(lat_origin_r);
    s2_dlon_r <= DW'(s1_lon_r) - DW'(lon_origin_r);

    s3_q_r    <= s2_q_r;
    s3_idx_r  <= s2_idx_r;
    s3_ent_r  <= s2_ent_r;
    s3_plat_r <= MW'(s2_dlat_r * $signed({1'b0, lat_scale_r}));
    s3_plon_r <= MW'(s2_dlon_r * $signed({1'b0, lon_scale_r}));

    s4_q_r   <= s3_q_r;
    s4_idx_r <= s3_idx_r;
    s4_ent_r <= s3_ent_r;
    s4_in_r  <= loc_y.in && loc_x.in;
    s4_y0_r  <= loc_y.base[RW-1:0];
    s4_y1_r  <= loc_y.next[RW-1:0];
    s4_x0_r  <= loc_x.base[XW-1:0];
    s4_x1_r  <= loc_x.next[XW-1:0];
    s4_ty_r  <= loc_y.frac;
    s4_tx_r  <= loc_x.frac;

    s5_q_r   <= s4_q_r;
    s5_idx_r <= s4_idx_r;
    s5_ent_r <= s4_ent_r;
    s5_in_r  <= s4_in_r;
    s5_r0_r  <= AW0'(s4_y0_r * cols);
    s5_r1_r  <= AW0'(s4_y1_r * cols);
    s5_x0_r  <= s4_x0_r;
    s5_x1_r  <= s4_x1_r;
    s5_ty_r  <= s4_ty_r;
    s5_tx_r  <= s4_tx_r;

    s6_in_r <= s5_in_r;
    s6_ty_r <= s5_ty_r;
    s6_tx_r <= s5_tx_r;

    s7_ok_r  <= s6_in_r && c00[CELL_W] && c01[CELL_W] && c10[CELL_W] && c11[CELL_W];
    s7_ty_r  <= s6_ty_r;
    s7_p00_r <= P1W'($signed(c00[CELL_W-1:0]) * $signed({1'b0, wx0}));
    s7_p01_r <= P1W'($signed(c01[CELL_W-1:0]) * $signed({1'b0, wx1}));
    s7_p10_r <= P1W'($signed(c10[CELL_W-1:0]) * $signed({1'b0, wx0}));
    s7_p11_r <= P1W'($signed(c11[CELL_W-1:0]) * $signed({1'b0, wx1}));

    s8_ok_r <= s7_ok_r;
    s8_ty_r <= s7_ty_r;
    s8_lo_r <= L1W'(s7_p00_r) + L1W'(s7_p01_r);
    s8_up_r <= L1W'(s7_p10_r) + L1W'(s7_p11_r);

    s9_ok_r <= s8_ok_r;
    s9_ml_r <= P2W'(s8_lo_r * $signed({1'b0, wy0}));
    s9_mu_r <= P2W'(s8_up_r * $signed({1'b0, wy1}));

    out_valid_res <= s9_ok_r;
    out_value     <= s9_ok_r ? acc[2*F +: CELL_W] : '0;
  end

endmodule
`default_nettype wire
